// ===== rtl/enms_pkg.sv =====
// ----------------------------------------------------------------------------
// enms_pkg: shared types and constants for edge non-maximum suppression
// Sector codes, register indexes, field widths and the fixed-point angle
// boundaries used to sort a gradient direction into one of four sectors.
// ----------------------------------------------------------------------------
package enms_pkg;

  // Default parameter values
  localparam int MAX_WIDTH_DEF       = 1024;
  localparam int MAG_BITS_DEF        = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 12;

  // Configuration word layout
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 13;
  localparam int WIDTH_CFG_W  = 11;
  localparam int HEIGHT_CFG_W = 13;

  // Row position runs to image_height + 1 while the frame tail drains
  localparam int ROW_W = 14;

  // Frame size after reset
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // pi/8 in Q0.32
  localparam longint unsigned PI8_Q32 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Direction sectors and the neighbor pair each compares against
  typedef enum logic [1:0] {
    SEC_VERT      = 2'd0,  // up and down
    SEC_DIAG_DOWN = 2'd1,  // up-left and down-right
    SEC_HORZ      = 2'd2,  // left and right
    SEC_DIAG_UP   = 2'd3   // up-right and down-left
  } sector_t;

  // Per-pixel result control carried from the position counters
  typedef struct packed {
    logic res;   // this item releases a result
    logic up;    // upper neighbor inside the frame
    logic dn;    // lower neighbor inside the frame
    logic lf;    // left neighbor inside the frame
    logic rt;    // right neighbor inside the frame
    logic last;  // result of the frame's last pixel
  } res_ctl_t;

  // k * pi/8 rounded down to the angle's fraction bits
  function automatic longint sector_edge(int k, int frac);
    longint unsigned prod;
    prod = 64'(k) * PI8_Q32;
    return longint'(prod >> (32 - frac));
  endfunction

  // pi rounded to nearest at the angle's fraction bits
  function automatic longint pi_fixed(int frac);
    longint unsigned prod;
    prod = 64'd8 * PI8_Q32 + (64'd1 << (31 - frac));
    return longint'(prod >> (32 - frac));
  endfunction

  // Last column index for a raw width setting: zero acts as one, clamp at max
  function automatic int last_col_of(int raw, int max_w);
    int lc;
    if (raw == 0) begin
      lc = 0;
    end else if (raw > max_w) begin
      lc = max_w - 1;
    end else begin
      lc = raw - 1;
    end
    return lc;
  endfunction

  // Last row index for a raw height setting: zero acts as one
  function automatic int last_row_of(int raw);
    int lr;
    if (raw == 0) begin
      lr = 0;
    end else begin
      lr = raw - 1;
    end
    return lr;
  endfunction

endpackage

// ===== rtl/edge_non_maximum_suppression.sv =====
// ----------------------------------------------------------------------------
// edge_non_maximum_suppression: Canny non-maximum suppression on a pixel stream
// Keeps a pixel's gradient magnitude only where it is a local maximum along
// its gradient direction, using two line stores held in one block memory.
// ----------------------------------------------------------------------------
// Usage
//   Input words (in_valid / in_stall) carry one raster-order pixel each:
//   magnitude, signed angle and a flush flag. A flush word enters magnitude 0
//   and advances the pipeline; width+1 flush words after the last pixel drain
//   the frame. The result of a pixel is released by the word that arrives
//   width+1 positions later; the first width+1 words of a frame release none.
//   Result words (out_valid / out_stall) carry the kept magnitude and a flag
//   on the frame's last pixel, after which the position restarts at zero.
//   A released result passes the memory read stage, then the output register.
//   Throughput: one word per cycle while results are not stalled, set by
//   the single read-modify-write pass through the line memory per word;
//   back-to-back reuse of one column (width one) is forwarded past the memory.
//   A stalled result holds in the output register while one more word may
//   still enter the read stage; further input stalls until the result leaves.
//   Reset clears the pipeline and sets a 640 x 480 frame. The line memory is
//   not cleared: entries are always written before any result depends on them.
//   Configuration writes (cfg_valid / cfg_ready, always ready) restart the
//   frame; the user issues them only while no word is in flight (unchecked).
// ----------------------------------------------------------------------------
module edge_non_maximum_suppression #(
  parameter int MAX_WIDTH       = enms_pkg::MAX_WIDTH_DEF,
  parameter int MAG_BITS        = enms_pkg::MAG_BITS_DEF,
  parameter int ANGLE_FRAC_BITS = enms_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // pixel input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [MAG_BITS-1:0]                 in_grad_magnitude,
  input  logic signed [ANGLE_FRAC_BITS+2:0]   in_grad_angle,
  input  logic                                in_flush,
  // result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [MAG_BITS-1:0]                 out_kept_magnitude,
  output logic                                out_frame_last,
  // configuration write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [enms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [enms_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import enms_pkg::*;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ANG_W     = ANGLE_FRAC_BITS + 3;
  localparam int ANG_EXT_W = ANG_W + 1;

  localparam logic signed [ANG_EXT_W-1:0] EDGE1 =
    ANG_EXT_W'(sector_edge(1, ANGLE_FRAC_BITS));
  localparam logic signed [ANG_EXT_W-1:0] EDGE3 =
    ANG_EXT_W'(sector_edge(3, ANGLE_FRAC_BITS));
  localparam logic signed [ANG_EXT_W-1:0] EDGE5 =
    ANG_EXT_W'(sector_edge(5, ANGLE_FRAC_BITS));
  localparam logic signed [ANG_EXT_W-1:0] EDGE7 =
    ANG_EXT_W'(sector_edge(7, ANGLE_FRAC_BITS));
  localparam logic signed [ANG_EXT_W-1:0] PI_FIX =
    ANG_EXT_W'(pi_fixed(ANGLE_FRAC_BITS));

  localparam logic [COL_W-1:0] RESET_LAST_COL = COL_W'(last_col_of(RESET_WIDTH, MAX_WIDTH));
  localparam logic [ROW_W-1:0] RESET_LAST_ROW = ROW_W'(last_row_of(RESET_HEIGHT));

  // One line memory word: upper row, centre row, centre-row sector
  typedef struct packed {
    logic [MAG_BITS-1:0] up;
    logic [MAG_BITS-1:0] ctr;
    sector_t             sec;
  } line_word_t;

  // Frame geometry
  logic [COL_W-1:0] last_col_r, last_col_nxt;
  logic [ROW_W-1:0] last_row_r, last_row_nxt;

  // Stream position of the next word
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // Read stage
  logic                s1_valid_r, s1_valid_nxt;
  logic [COL_W-1:0]    s1_addr_r;
  logic [MAG_BITS-1:0] s1_mag_r;
  sector_t             s1_sec_r;
  res_ctl_t            s1_ctl_r;
  logic                fwd_r;
  line_word_t          fwd_word_r;
  line_word_t          rd_word_r;

  // Window columns (left and middle of the previous window) and sector delay
  logic [MAG_BITS-1:0] win_c1_r [3];
  logic [MAG_BITS-1:0] win_c2_r [3];
  sector_t             sec_dly_r, sec_dly_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [MAG_BITS-1:0] out_mag_r;
  logic                out_last_r;

  line_word_t line_mem [MAX_WIDTH];

  logic                    accept;
  logic                    out_free;
  logic                    s1_go;
  logic                    cfg_we;
  logic                    cfg_restart;
  logic signed [ANG_EXT_W-1:0] ang_ext;
  logic signed [ANG_EXT_W-1:0] ang_fold;
  sector_t                 in_sec;
  logic [MAG_BITS-1:0]     in_mag;
  logic                    at_col0;
  logic                    have;
  logic [ROW_W-1:0]        cr;
  logic [COL_W-1:0]        cc;
  res_ctl_t                in_ctl;
  line_word_t              rd_word;
  line_word_t              wr_word;
  logic [MAG_BITS-1:0]     ctr_mag;
  logic [MAG_BITS-1:0]     nb1, nb2;
  logic                    ok1, ok2;
  logic [MAG_BITS-1:0]     keep_mag;

  // Handshakes
  assign out_free  = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Fold a negative angle up by pi and pick its sector
  always_comb begin
    ang_ext = {in_grad_angle[ANG_W-1], in_grad_angle};
    if (ang_ext[ANG_EXT_W-1]) begin
      ang_fold = ang_ext + PI_FIX;
    end else begin
      ang_fold = ang_ext;
    end
    if (in_flush || ang_fold <= EDGE1 || ang_fold > EDGE7) begin
      in_sec = SEC_VERT;
    end else if (ang_fold <= EDGE3) begin
      in_sec = SEC_DIAG_DOWN;
    end else if (ang_fold <= EDGE5) begin
      in_sec = SEC_HORZ;
    end else begin
      in_sec = SEC_DIAG_UP;
    end
    in_mag = in_flush ? '0 : in_grad_magnitude;
  end

  // Locate the centre pixel this word releases and its in-frame neighbors
  always_comb begin
    at_col0 = (col_r == '0);
    if (at_col0) begin
      have = (row_r >= ROW_W'(2));
      cr   = row_r - ROW_W'(2);
      cc   = last_col_r;
    end else begin
      have = (row_r != '0);
      cr   = row_r - ROW_W'(1);
      cc   = col_r - COL_W'(1);
    end
    in_ctl.res  = have && (cr <= last_row_r);
    in_ctl.up   = (cr != '0);
    in_ctl.dn   = (cr != last_row_r);
    in_ctl.lf   = (cc != '0);
    in_ctl.rt   = (cc != last_col_r);
    in_ctl.last = in_ctl.res && (cr == last_row_r) && (cc == last_col_r);
  end

  // Advance the stream position; restart after the last result or a config write
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    last_col_nxt = last_col_r;
    last_row_nxt = last_row_r;
    cfg_restart  = 1'b0;
    if (cfg_we) begin
      cfg_restart = 1'b1;
      col_nxt     = '0;
      row_nxt     = '0;
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH: begin
          last_col_nxt = COL_W'(last_col_of(int'(cfg_data[WIDTH_CFG_W-1:0]), MAX_WIDTH));
        end
        REG_IMAGE_HEIGHT: begin
          last_row_nxt = ROW_W'(last_row_of(int'(cfg_data[HEIGHT_CFG_W-1:0])));
        end
        default: begin
          cfg_restart = 1'b0;
          col_nxt     = col_r;
          row_nxt     = row_r;
        end
      endcase
    end else if (accept) begin
      if (in_ctl.last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (col_r == last_col_r) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // Memory read data, with the word written in the same cycle forwarded
  assign rd_word = fwd_r ? fwd_word_r : rd_word_r;

  // Shift the column down the line stores
  always_comb begin
    wr_word.up  = rd_word.ctr;
    wr_word.ctr = s1_mag_r;
    wr_word.sec = s1_sec_r;
  end

  // Compare the centre against its two neighbors along the delayed sector
  always_comb begin
    ctr_mag = win_c2_r[1];
    case (sec_dly_r)
      SEC_VERT: begin
        nb1 = win_c2_r[0];
        ok1 = s1_ctl_r.up;
        nb2 = win_c2_r[2];
        ok2 = s1_ctl_r.dn;
      end
      SEC_DIAG_DOWN: begin
        nb1 = win_c1_r[0];
        ok1 = s1_ctl_r.up && s1_ctl_r.lf;
        nb2 = s1_mag_r;
        ok2 = s1_ctl_r.dn && s1_ctl_r.rt;
      end
      SEC_HORZ: begin
        nb1 = win_c1_r[1];
        ok1 = s1_ctl_r.lf;
        nb2 = rd_word.ctr;
        ok2 = s1_ctl_r.rt;
      end
      default: begin
        nb1 = rd_word.up;
        ok1 = s1_ctl_r.up && s1_ctl_r.rt;
        nb2 = win_c1_r[2];
        ok2 = s1_ctl_r.dn && s1_ctl_r.lf;
      end
    endcase
    if ((ok1 && ctr_mag < nb1) || (ok2 && ctr_mag < nb2)) begin
      keep_mag = '0;
    end else begin
      keep_mag = ctr_mag;
    end
  end

  // Control next values
  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (out_free) begin
      out_valid_nxt = s1_valid_r && s1_ctl_r.res;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    if (cfg_restart) begin
      sec_dly_nxt = SEC_VERT;
    end else if (s1_go) begin
      sec_dly_nxt = s1_ctl_r.last ? SEC_VERT : rd_word.sec;
    end else begin
      sec_dly_nxt = sec_dly_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r  <= RESET_LAST_COL;
      last_row_r  <= RESET_LAST_ROW;
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sec_dly_r   <= SEC_VERT;
      fwd_r       <= 1'b0;
    end else begin
      last_col_r  <= last_col_nxt;
      last_row_r  <= last_row_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      sec_dly_r   <= sec_dly_nxt;
      if (accept) begin
        fwd_r <= s1_go && (s1_addr_r == col_r);
      end
    end
  end

  // Line memory: read on accept, write back when the read stage retires
  always_ff @(posedge clk) begin
    if (s1_go) begin
      line_mem[s1_addr_r] <= wr_word;
    end
    if (accept) begin
      rd_word_r <= line_mem[col_r];
    end
  end

  // Read stage payload and forwarded write word
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r  <= col_r;
      s1_mag_r   <= in_mag;
      s1_sec_r   <= in_sec;
      s1_ctl_r   <= in_ctl;
      fwd_word_r <= wr_word;
    end
  end

  // Slide the window one column
  always_ff @(posedge clk) begin
    if (s1_go) begin
      win_c1_r    <= win_c2_r;
      win_c2_r[0] <= rd_word.up;
      win_c2_r[1] <= rd_word.ctr;
      win_c2_r[2] <= s1_mag_r;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_mag_r  <= keep_mag;
      out_last_r <= s1_ctl_r.last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kept_magnitude = out_mag_r;
  assign out_frame_last     = out_last_r;

endmodule

// ===== rtl/enms_checker.sv =====
// ----------------------------------------------------------------------------
// enms_checker: port-level assertions for edge non-maximum suppression
// Watches the top level's channels for output hold, reset and stall behavior.
// ----------------------------------------------------------------------------
module enms_checker #(
  parameter int MAG_BITS = enms_pkg::MAG_BITS_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [MAG_BITS-1:0] out_kept_magnitude,
  input logic                out_frame_last
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_kept_magnitude) && $stable(out_frame_last))
    else $error("result word changed while stalled");

  // Drop all results on reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Stall input only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A new result traces back through the read stage to an accepted input word
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result appeared without an accepted input word");

endmodule

bind edge_non_maximum_suppression enms_checker #(
  .MAG_BITS(MAG_BITS)
) u_enms_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_kept_magnitude (out_kept_magnitude),
  .out_frame_last     (out_frame_last)
);

// ===== sim/tb_edge_non_maximum_suppression.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_edge_non_maximum_suppression: self-checking bench for edge NMS
// Streams raster pixels through the block, predicts every kept magnitude and
// frame-last flag with a local line-store model, and compares each result
// word in order. Covers sector boundaries, frame sizes at their limits,
// flush and tail words, and input/output backpressure.
// ----------------------------------------------------------------------------
module tb_edge_non_maximum_suppression;
  import enms_pkg::*;

  localparam int MAG_W        = MAG_BITS_DEF;
  localparam int ANG_W        = ANGLE_FRAC_BITS_DEF + 3;
  localparam int MAX_W        = MAX_WIDTH_DEF;
  localparam int ANG_SHIFT    = 32 - ANGLE_FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS = 150;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 600000;

  // Sector boundaries k*pi/8 truncated, and pi rounded, in Q3.12
  localparam int EDGE_1 = int'((64'd1 * PI8_Q32) >> ANG_SHIFT);
  localparam int EDGE_3 = int'((64'd3 * PI8_Q32) >> ANG_SHIFT);
  localparam int EDGE_5 = int'((64'd5 * PI8_Q32) >> ANG_SHIFT);
  localparam int EDGE_7 = int'((64'd7 * PI8_Q32) >> ANG_SHIFT);
  localparam int PI_Q   = int'((64'd8 * PI8_Q32 + (64'd1 << (ANG_SHIFT - 1))) >> ANG_SHIFT);

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             last;
  } kept_word_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_SPARSE,
    RX_PERIODIC,
    RX_HEAVY
  } rx_style_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [MAG_W-1:0]        in_grad_magnitude;
  logic signed [ANG_W-1:0] in_grad_angle;
  logic                    in_flush;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [MAG_W-1:0]        out_kept_magnitude;
  logic                    out_frame_last;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  // Model state: line stores, window, stream position, frame size
  logic [MAG_W-1:0] upper_line  [MAX_W];
  logic [MAG_W-1:0] centre_line [MAX_W];
  sector_t          sector_line [MAX_W];
  logic [MAG_W-1:0] win [9];
  int unsigned      col_pos;
  int unsigned      row_pos;
  sector_t          sector_hold;
  int unsigned      width_raw;
  int unsigned      height_raw;

  kept_word_t pending_kept[$];

  int        fail_count    = 0;
  int        items_sent    = 0;
  int        cycle_count   = 0;
  bit        tx_gaps       = 1'b0;
  int        burst_left    = 0;
  int        hold_requests = 0;
  int        hold_served   = 0;
  int        hold_left     = 0;
  int        pattern_left  = 0;
  rx_style_t rx_style      = RX_FREE;

  edge_non_maximum_suppression dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_grad_magnitude  (in_grad_magnitude),
    .in_grad_angle      (in_grad_angle),
    .in_flush           (in_flush),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kept_magnitude (out_kept_magnitude),
    .out_frame_last     (out_frame_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver stall: a style redrawn whenever its pattern counter runs out, plus long holds on request
  always @(negedge clk) begin
    if (pattern_left == 0) begin
      rx_style     = rx_style_t'($urandom_range(3));
      pattern_left = $urandom_range(300, 40);
    end
    pattern_left--;
    if (hold_left == 0 && hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_style)
        RX_FREE:     out_stall <= 1'b0;
        RX_SPARSE:   out_stall <= ($urandom_range(99) < 30);
        RX_PERIODIC: out_stall <= ((pattern_left % 5) < 2);
        default:     out_stall <= ($urandom_range(99) < 75);
      endcase
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    kept_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_kept.size() == 0) begin
        $error("unexpected result word: kept_magnitude %0d frame_last %0b",
               out_kept_magnitude, out_frame_last);
        fail_count++;
      end else begin
        want = pending_kept.pop_front();
        if (out_kept_magnitude !== want.mag) begin
          $error("kept_magnitude: expected %0d, got %0d", want.mag, out_kept_magnitude);
          fail_count++;
        end
        if (out_frame_last !== want.last) begin
          $error("frame_last: expected %0b, got %0b", want.last, out_frame_last);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- model

  function automatic int unsigned frame_w();
    if (width_raw == 0) return 1;
    if (width_raw > MAX_W) return MAX_W;
    return width_raw;
  endfunction

  function automatic int unsigned frame_h();
    return (height_raw == 0) ? 1 : height_raw;
  endfunction

  // Fold negative angles by pi, then bin into pi/4-wide sectors
  function automatic sector_t sector_of(input logic signed [ANG_W-1:0] ang);
    int a;
    a = ang;
    if (a < 0) a = a + PI_Q;
    if (a <= EDGE_1 || a > EDGE_7) return SEC_VERT;
    if (a <= EDGE_3) return SEC_DIAG_DOWN;
    if (a <= EDGE_5) return SEC_HORZ;
    return SEC_DIAG_UP;
  endfunction

  task automatic restart_position();
    col_pos     = 0;
    row_pos     = 0;
    sector_hold = SEC_VERT;
  endtask

  task automatic clear_model();
    int i;
    width_raw  = RESET_WIDTH;
    height_raw = RESET_HEIGHT;
    for (i = 0; i < MAX_W; i++) begin
      upper_line[i]  = '0;
      centre_line[i] = '0;
      sector_line[i] = SEC_VERT;
    end
    for (i = 0; i < 9; i++) win[i] = '0;
    restart_position();
  endtask

  // Advance the window by one accepted word and queue the result it releases
  task automatic suppress_pixel(input logic [MAG_W-1:0] mag_in,
                                input logic signed [ANG_W-1:0] ang,
                                input logic fl);
    int unsigned w, h, ic, ir, cr, cc;
    logic [MAG_W-1:0] mag, ctr, keep;
    sector_t sec, centre_sec;
    logic have, up, dn, lf, rt, ok1, ok2, last;
    int n1, n2;
    kept_word_t res;
    w          = frame_w();
    h          = frame_h();
    ic         = col_pos;
    ir         = row_pos;
    mag        = fl ? '0 : mag_in;
    sec        = fl ? SEC_VERT : sector_of(ang);
    centre_sec = sector_hold;
    if (ic >= w) ic = 0;

    // shift window left, load new column
    win[0] = win[1]; win[1] = win[2];
    win[3] = win[4]; win[4] = win[5];
    win[6] = win[7]; win[7] = win[8];
    win[2] = upper_line[ic];
    win[5] = centre_line[ic];
    win[8] = mag;
    upper_line[ic]  = centre_line[ic];
    centre_line[ic] = mag;
    sector_hold     = sector_line[ic];
    sector_line[ic] = sec;

    // locate the centre pixel, if this word releases one
    have = 1'b0;
    cr   = 0;
    cc   = 0;
    last = 1'b0;
    if (ic == 0) begin
      if (ir >= 2) begin
        have = 1'b1;
        cr   = ir - 2;
        cc   = w - 1;
      end
    end else if (ir >= 1) begin
      have = 1'b1;
      cr   = ir - 1;
      cc   = ic - 1;
    end

    if (have && cr < h) begin
      ctr  = win[4];
      keep = ctr;
      up   = (cr > 0);
      dn   = (cr < h - 1);
      lf   = (cc > 0);
      rt   = (cc < w - 1);
      case (centre_sec)
        SEC_VERT: begin
          n1 = 1; ok1 = up; n2 = 7; ok2 = dn;
        end
        SEC_DIAG_DOWN: begin
          n1 = 0; ok1 = up && lf; n2 = 8; ok2 = dn && rt;
        end
        SEC_HORZ: begin
          n1 = 3; ok1 = lf; n2 = 5; ok2 = rt;
        end
        default: begin
          n1 = 2; ok1 = up && rt; n2 = 6; ok2 = dn && lf;
        end
      endcase
      if (ok1 && ctr < win[n1]) keep = '0;
      if (ok2 && ctr < win[n2]) keep = '0;
      last     = (cr == h - 1) && (cc == w - 1);
      res.mag  = keep;
      res.last = last;
      pending_kept.push_back(res);
    end

    // advance position; the frame's last result restarts it
    if (last) begin
      restart_position();
    end else begin
      ic++;
      if (ic >= w) begin
        ic = 0;
        if (ir < 32'hFFFF) ir++;
      end
      col_pos = ic;
      row_pos = ir;
    end
  endtask

  // ---------------------------------------------------------------- drivers

  // Send one input word; bursts with random gaps when tx_gaps is set
  task automatic send_word(input logic [MAG_W-1:0] mag,
                           input logic signed [ANG_W-1:0] ang,
                           input logic fl);
    int gap;
    if (tx_gaps && burst_left <= 0) begin
      gap = $urandom_range(6, 1);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(24, 1);
    end
    in_valid          <= 1'b1;
    in_grad_magnitude <= mag;
    in_grad_angle     <= ang;
    in_flush          <= fl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    suppress_pixel(mag, ang, fl);
    burst_left--;
    items_sent++;
    @(negedge clk);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Idle the input and wait until every predicted word has arrived
  task automatic wait_drained();
    release_input();
    while (pending_kept.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) width_raw = value[WIDTH_CFG_W-1:0];
    else height_raw = value[HEIGHT_CFG_W-1:0];
    restart_position();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] w_word,
                           input logic [CFG_DATA_W-1:0] h_word);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, w_word);
    write_reg(REG_IMAGE_HEIGHT, h_word);
  endtask

  // Magnitudes favor small values so ties and suppression both occur
  task automatic rand_pixel(output logic [MAG_W-1:0] mag,
                            output logic signed [ANG_W-1:0] ang);
    int pick, a;
    pick = $urandom_range(99);
    if (pick < 40) mag = MAG_W'($urandom_range(7));
    else if (pick < 50) mag = ($urandom_range(1) != 0) ? {MAG_W{1'b1}} : '0;
    else mag = MAG_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 70) begin
      a = int'($urandom_range(2 * PI_Q)) - PI_Q;
    end else if (pick < 85) begin
      case ($urandom_range(4))
        0:       a = EDGE_1;
        1:       a = EDGE_3;
        2:       a = EDGE_5;
        3:       a = EDGE_7;
        default: a = PI_Q;
      endcase
      a = a + int'($urandom_range(2)) - 1;
      if ($urandom_range(1) != 0) a = a - PI_Q;
    end else begin
      a = $urandom;
    end
    ang = a[ANG_W-1:0];
  endtask

  // Unstructured words, mostly pixels with some flushes
  task automatic send_noise(input int n);
    logic [MAG_W-1:0] m;
    logic signed [ANG_W-1:0] a;
    repeat (n) begin
      rand_pixel(m, a);
      send_word(m, a, $urandom_range(99) < 10);
    end
  endtask

  // One full frame plus its width+1 drain words; optional mid-frame pause
  task automatic send_frame(input int flush_pct, input int tail_px_pct, input int pause_at);
    int w, h, i;
    logic [MAG_W-1:0] m;
    logic signed [ANG_W-1:0] a;
    w = frame_w();
    h = frame_h();
    for (i = 0; i < w * h; i++) begin
      if (i == pause_at) wait_drained();
      rand_pixel(m, a);
      send_word(m, a, $urandom_range(99) < flush_pct);
    end
    for (i = 0; i <= w; i++) begin
      rand_pixel(m, a);
      send_word(m, a, !($urandom_range(99) < tail_px_pct));
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Reset frame size: 640 wide, so results start after 641 words
  task automatic test_reset_size();
    tx_gaps = 1'b1;
    send_noise(650);
    wait_drained();
  endtask

  // 3x3 frames hitting every sector boundary, folding and out-of-range angles
  task automatic test_directed_sectors();
    int mag_set [18] = '{100, 65535, 7, 0, 500, 500, 65535, 1, 300,
                         0, 200, 200, 9, 9, 65535, 3, 40000, 40000};
    int ang_set [18] = '{EDGE_1, EDGE_1 + 1, EDGE_3, EDGE_3 + 1, EDGE_5,
                         EDGE_5 + 1, EDGE_7, EDGE_7 + 1, -PI_Q,
                         -1, PI_Q, -4000, -16384, 16383, -8000, -EDGE_1, 0, -12000};
    int i;
    tx_gaps = 1'b0;
    set_frame(13'd3, 13'd3);
    for (i = 0; i < 9; i++) send_word(MAG_W'(mag_set[i]), ANG_W'(ang_set[i]), 1'b0);
    // tail: a pixel among the flushes must not disturb anything
    send_word('0, '0, 1'b1);
    send_word({MAG_W{1'b1}}, ANG_W'(EDGE_3), 1'b0);
    send_word('0, '0, 1'b1);
    send_word('0, '0, 1'b1);
    // second frame back to back, with a flush in the centre
    for (i = 9; i < 18; i++) send_word(MAG_W'(mag_set[i]), ANG_W'(ang_set[i]), i == 13);
    repeat (4) send_word('0, '0, 1'b1);
    wait_drained();
  endtask

  // Width and height at zero, width above the maximum, height at its top code
  task automatic test_size_extremes();
    tx_gaps = 1'b1;
    set_frame(13'h1800, 13'd0);
    repeat (2) send_frame(0, 50, -1);
    set_frame(13'h07FF, 13'd4096);
    send_noise(1040);
    set_frame(13'd1, 13'h1FFF);
    send_noise(40);
    wait_drained();
  endtask

  // Long receiver hold with a continuous sender, then a sender pause mid-frame
  task automatic test_backpressure();
    set_frame(13'd5, 13'd6);
    tx_gaps = 1'b0;
    hold_requests++;
    send_frame(5, 10, -1);
    tx_gaps = 1'b1;
    hold_requests++;
    send_frame(5, 10, 15);
    wait_drained();
  endtask

  // Random frame sizes, frame counts and aborted frames
  task automatic test_random_frames();
    int start, w, h, pick;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 70) w = $urandom_range(8, 1);
      else if (pick < 95) w = $urandom_range(24, 9);
      else w = $urandom_range(64, 25);
      h = (w > 24) ? $urandom_range(3, 1) : $urandom_range(8, 1);
      tx_gaps = ($urandom_range(3) != 0);
      wait_drained();
      if ($urandom_range(4) != 0)
        write_reg(REG_IMAGE_WIDTH, {2'($urandom_range(3)), 11'(w)});
      write_reg(REG_IMAGE_HEIGHT, 13'(h));
      repeat ($urandom_range(3, 1))
        send_frame($urandom_range(10), $urandom_range(30), -1);
      // leave a frame unfinished now and then
      if ($urandom_range(3) == 0)
        send_noise($urandom_range(frame_w() * frame_h()));
    end
    wait_drained();
  endtask

  initial begin
    in_valid          = 1'b0;
    in_grad_magnitude = '0;
    in_grad_angle     = '0;
    in_flush          = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = REG_IMAGE_WIDTH;
    cfg_data          = '0;
    rst_n             = 1'b0;
    clear_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_size();
    test_directed_sectors();
    test_size_extremes();
    test_backpressure();
    test_random_frames();

    wait_drained();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
